// File: rtl/core/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types, constants and fixed-point helpers for the conjugate gradient
// step block.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned OPW       = DW + 1;
  localparam int unsigned PW        = 2 * DW;
  localparam int unsigned CNTW      = 7;
  localparam int unsigned MAX_LEN_D = 64;
  localparam int unsigned DIVW      = PW + 16;
  localparam logic [DW-1:0] STEP_RESET = 32'h0000_8000;
  localparam logic [2:0]    ADDR_STEP  = 3'd0;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MULN = 11'b000_0000_0010,
    S_ACCN = 11'b000_0000_0100,
    S_ACCD = 11'b000_0000_1000,
    S_BETA = 11'b000_0001_0000,
    S_DIV  = 11'b000_0010_0000,
    S_ERD  = 11'b000_0100_0000,
    S_EMB  = 11'b000_1000_0000,
    S_ED   = 11'b001_0000_0000,
    S_EMS  = 11'b010_0000_0000,
    S_EP   = 11'b100_0000_0000
  } state_t;

  // Q32.32 to Q16.16, round half up (arithmetic shift is a floor)
  function automatic logic signed [PW-17:0] rnd_q16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + 64'sd32768;
    return s[PW-1:16];
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-15:0] v);
    logic signed [DW-1:0] r;
    if (v > 50'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -50'sd2147483648) r = 32'sh8000_0000;
    else r = v[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [PW-1:0] sat_add64(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
    logic signed [PW-1:0] s;
    s = a + b;
    if (a[PW-1] == b[PW-1] && s[PW-1] != a[PW-1])
      s = b[PW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    return s;
  endfunction

endpackage

// File: rtl/core/cgs_mul.sv
// ----------------------------------------------------------------------------
// cgs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cgs_mul (
  input  logic                              clk,
  input  logic signed [cgs_pkg::OPW-1:0]    op_a,
  input  logic signed [cgs_pkg::OPW-1:0]    op_b,
  output logic signed [cgs_pkg::PW-1:0]     prod
);
  import cgs_pkg::*;

  logic signed [2*OPW-1:0] full;
  logic signed [PW-1:0]    prod_r;

  // all operand pairs used here keep the product inside 64 bits
  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= full[PW-1:0];
  end

  assign prod = prod_r;
endmodule

// File: rtl/core/conjugate_gradient_step_top.sv
// ----------------------------------------------------------------------------
// conjugate_gradient_step_top
// Polak-Ribiere conjugate gradient step in Q16.16: loads and accumulates
// vector elements, forms beta, then emits new direction and position.
// ----------------------------------------------------------------------------
//  channel | handshake                      | payload
//  input   | start / busy                   | in_cur_pos .. in_last_in
//  result  | out_valid, one-cycle strobe    | out_new_pos .. out_last_out
//  config  | psel/penable/pwrite/pready     | paddr, pwdata, prdata
//
// each element is handled in order: accept, then two multiplier passes through
// the shared multiplier and two saturating accumulates
// on the last element: beta setup, bit-serial division (skipped on restart or
// zero denominator), then the emit steps ERD, EMB, ED, EMS, EP per stored element
// synchronous active-low reset; stores are not cleared, count resets to 0
// results are strobed for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
module conjugate_gradient_step_top #(
  parameter int unsigned MAX_LEN = cgs_pkg::MAX_LEN_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [cgs_pkg::DW-1:0]   in_cur_pos,
  input  logic signed [cgs_pkg::DW-1:0]   in_gradient,
  input  logic signed [cgs_pkg::DW-1:0]   in_prev_gradient,
  input  logic signed [cgs_pkg::DW-1:0]   in_prev_direction,
  input  logic                            in_restart,
  input  logic                            in_last_in,
  output logic                            out_valid,
  output logic signed [cgs_pkg::DW-1:0]   out_new_pos,
  output logic signed [cgs_pkg::DW-1:0]   out_new_direction,
  output logic                            out_zero_denominator,
  output logic                            out_last_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [cgs_pkg::DW-1:0]          pwdata,
  output logic [cgs_pkg::DW-1:0]          prdata,
  output logic                            pready
);
  import cgs_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNTW-1:0] LEN = CNTW'(MAX_LEN);

  state_t state_r, state_nxt;

  logic [DW-1:0]         step_r;
  logic [CNTW-1:0]       count_r, k_r;
  logic signed [PW-1:0]  num_r, den_r;
  logic signed [DW-1:0]  g_r, go_r, beta_r, d_r;
  logic                  stored_r, last_r, restart_r, zd_r;
  logic [DIVW-1:0]       dvd_r;
  logic [PW:0]           rem_r;
  logic [DW-1:0]         q_r;
  logic                  ovf_r, neg_r;
  logic [CNTW-1:0]       dcnt_r;

  logic [3*DW-1:0]       mem [MAX_LEN];
  logic [3*DW-1:0]       rd_r;
  logic signed [DW-1:0]  rd_pos, rd_grad, rd_dir;

  logic signed [OPW-1:0] op_a, op_b;
  logic signed [PW-1:0]  prod;

  logic                  accept, cfg_wr;
  logic                  out_valid_r, last_o_r, zd_o_r;
  logic signed [DW-1:0]  pos_o_r, dir_o_r;

  logic [PW:0]           rem_sh;
  logic                  q_bit;
  logic [PW-1:0]         mag;
  logic signed [PW-15:0] d_wide, p_wide;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_STEP[2]) ? step_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_wr && paddr[2] == ADDR_STEP[2]) begin
      step_r <= pwdata;
    end
  end

  // element store: position, gradient, old direction in one word
  always_ff @(posedge clk) begin
    if (accept && count_r < LEN) begin
      mem[count_r[AW-1:0]] <= {in_cur_pos, in_gradient, in_prev_direction};
    end
    rd_r <= mem[k_r[AW-1:0]];
  end
  assign rd_pos  = rd_r[3*DW-1:2*DW];
  assign rd_grad = rd_r[2*DW-1:DW];
  assign rd_dir  = rd_r[DW-1:0];

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_MULN: begin
        op_a = OPW'(g_r);
        op_b = OPW'(g_r) - OPW'(go_r);
      end
      S_ACCN: begin
        op_a = OPW'(go_r);
        op_b = OPW'(go_r);
      end
      S_EMB: begin
        op_a = OPW'(beta_r);
        op_b = OPW'(rd_dir);
      end
      S_EMS: begin
        op_a = $signed({1'b0, step_r});
        op_b = OPW'(d_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  cgs_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign rem_sh = {rem_r[PW-1:0], dvd_r[DIVW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});
  assign mag    = num_r[PW-1] ? PW'(-num_r) : PW'(num_r);
  assign d_wide = (PW-14)'(rnd_q16(prod)) - (PW-14)'(rd_grad);
  assign p_wide = (PW-14)'(rnd_q16(prod)) + (PW-14)'(rd_pos);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_MULN;
      S_MULN: state_nxt = S_ACCN;
      S_ACCN: state_nxt = S_ACCD;
      S_ACCD: state_nxt = last_r ? S_BETA : S_IDLE;
      S_BETA: state_nxt = (restart_r || den_r <= 0) ? S_ERD : S_DIV;
      S_DIV:  if (dcnt_r == CNTW'(DIVW - 1)) state_nxt = S_ERD;
      S_ERD:  state_nxt = S_EMB;
      S_EMB:  state_nxt = S_ED;
      S_ED:   state_nxt = S_EMS;
      S_EMS:  state_nxt = S_EP;
      S_EP:   state_nxt = (k_r + 1'b1 == count_r) ? S_IDLE : S_ERD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      num_r       <= '0;
      den_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (accept && count_r < LEN) count_r <= count_r + 1'b1;
        S_ACCN: if (stored_r) num_r <= sat_add64(num_r, prod);
        S_ACCD: if (stored_r) den_r <= sat_add64(den_r, prod);
        S_EP: begin
          out_valid_r <= 1'b1;
          if (k_r + 1'b1 == count_r) begin
            k_r     <= '0;
            count_r <= '0;
            num_r   <= '0;
            den_r   <= '0;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (accept) begin
        g_r       <= in_gradient;
        go_r      <= in_prev_gradient;
        last_r    <= in_last_in;
        restart_r <= in_restart;
        stored_r  <= (count_r < LEN);
      end
      S_BETA: begin
        beta_r <= '0;
        zd_r   <= !restart_r && den_r <= 0;
        neg_r  <= num_r[PW-1];
        dvd_r  <= {mag, 16'h0};
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        rem_r  <= q_bit ? rem_sh - {1'b0, den_r} : rem_sh;
        dvd_r  <= {dvd_r[DIVW-2:0], 1'b0};
        q_r    <= {q_r[DW-2:0], q_bit};
        ovf_r  <= ovf_r | q_r[DW-1];
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == CNTW'(DIVW - 1)) begin
          if (ovf_r || q_r[DW-1] || q_r[DW-2])
            beta_r <= neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
          else
            beta_r <= neg_r ? -$signed({1'b0, q_r[DW-3:0], q_bit})
                            : $signed({1'b0, q_r[DW-3:0], q_bit});
        end
      end
      S_ED: d_r <= sat32(d_wide);
      S_EP: begin
        pos_o_r  <= sat32(p_wide);
        dir_o_r  <= d_r;
        zd_o_r   <= zd_r;
        last_o_r <= (k_r + 1'b1 == count_r);
      end
      default: ;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_new_pos          = pos_o_r;
  assign out_new_direction    = dir_o_r;
  assign out_zero_denominator = zd_o_r;
  assign out_last_out         = last_o_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted item did not raise busy");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EP)) else $error("stray result strobe");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEN) else $error("element count above store depth");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ERD |-> k_r < count_r) else $error("emit index past count");
`endif
endmodule

// File: dv/conjugate_gradient_step_top_test.sv
// ----------------------------------------------------------------------------
// conjugate_gradient_step_top_test
// Self-checking bench for the conjugate gradient step block. Vectors of
// elements are streamed through the start/busy port. A scoreboard predicts
// every strobed direction/position result in order and compares it field by
// field. The step size register is written between phases, with the amount of
// sender idling set per phase.
// ----------------------------------------------------------------------------
module conjugate_gradient_step_top_test;
  import cgs_pkg::*;

  typedef struct {
    logic signed [DW-1:0] pos;
    logic signed [DW-1:0] grad;
    logic signed [DW-1:0] pgrad;
    logic signed [DW-1:0] pdir;
    bit restart;
    bit last;
  } element_t;

  typedef struct {
    logic signed [DW-1:0] new_pos;
    logic signed [DW-1:0] new_dir;
    bit zero_den;
    bit last;
  } update_t;

  class cg_scoreboard;
    logic [DW-1:0] step;
    logic signed [DW-1:0] pos_mem[MAX_LEN_D];
    logic signed [DW-1:0] grad_mem[MAX_LEN_D];
    logic signed [DW-1:0] dir_mem[MAX_LEN_D];
    int count;
    longint num_acc;
    longint den_acc;
    update_t update_q[$];
    int errors;

    function new();
      step = STEP_RESET;
      count = 0;
      num_acc = 0;
      den_acc = 0;
      errors = 0;
    endfunction

    function longint add_clip(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
    endfunction

    // q32.32 to q16.16, round half up
    function longint q16_round(longint p);
      return (p + 64'sd32768) >>> 16;
    endfunction

    function logic signed [DW-1:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[DW-1:0];
    endfunction

    function void note_input(element_t e);
      longint g, go, beta, d, s;
      logic signed [79:0] wn, wd, q;
      bit zden;
      update_t u;
      if (count < MAX_LEN_D) begin
        g = e.grad;
        go = e.pgrad;
        pos_mem[count] = e.pos;
        grad_mem[count] = e.grad;
        dir_mem[count] = e.pdir;
        num_acc = add_clip(num_acc, g * (g - go));
        den_acc = add_clip(den_acc, go * go);
        count++;
      end
      if (!e.last) return;
      beta = 0;
      zden = 0;
      if (!e.restart) begin
        if (den_acc <= 0) zden = 1;
        else begin
          wn = num_acc;
          wn = wn <<< 16;
          wd = den_acc;
          q = wn / wd;
          if (q > 80'sd2147483647) beta = 64'sd2147483647;
          else if (q < -80'sd2147483648) beta = -64'sd2147483648;
          else beta = q[63:0];
        end
      end
      s = step;
      for (int k = 0; k < count; k++) begin
        d = clip32(q16_round(beta * longint'(dir_mem[k])) - longint'(grad_mem[k]));
        u.new_dir = d[DW-1:0];
        u.new_pos = clip32(longint'(pos_mem[k]) + q16_round(s * d));
        u.zero_den = zden;
        u.last = (k + 1 == count);
        update_q.push_back(u);
      end
      count = 0;
      num_acc = 0;
      den_acc = 0;
    endfunction

    function void check_result(update_t got);
      update_t want;
      if (update_q.size() == 0) begin
        $error("unexpected result: new_pos %0d new_direction %0d", got.new_pos,
               got.new_dir);
        errors++;
        return;
      end
      want = update_q.pop_front();
      if (got.new_pos !== want.new_pos) begin
        $error("new_pos expected %0d actual %0d", want.new_pos, got.new_pos);
        errors++;
      end
      if (got.new_dir !== want.new_dir) begin
        $error("new_direction expected %0d actual %0d", want.new_dir, got.new_dir);
        errors++;
      end
      if (got.zero_den !== want.zero_den) begin
        $error("zero_denominator expected %0b actual %0b", want.zero_den, got.zero_den);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_out expected %0b actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [DW-1:0] in_cur_pos = '0;
  logic signed [DW-1:0] in_gradient = '0;
  logic signed [DW-1:0] in_prev_gradient = '0;
  logic signed [DW-1:0] in_prev_direction = '0;
  logic in_restart = 0;
  logic in_last_in = 0;
  logic out_valid;
  logic signed [DW-1:0] out_new_pos;
  logic signed [DW-1:0] out_new_direction;
  logic out_zero_denominator;
  logic out_last_out;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [2:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;

  cg_scoreboard cg_sb;
  int idle_pct;
  int phase_items;

  conjugate_gradient_step_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cur_pos(in_cur_pos), .in_gradient(in_gradient),
    .in_prev_gradient(in_prev_gradient), .in_prev_direction(in_prev_direction),
    .in_restart(in_restart), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_new_pos(out_new_pos),
    .out_new_direction(out_new_direction),
    .out_zero_denominator(out_zero_denominator), .out_last_out(out_last_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    update_t got;
    if (rst_n && out_valid) begin
      got.new_pos = out_new_pos;
      got.new_dir = out_new_direction;
      got.zero_den = out_zero_denominator;
      got.last = out_last_out;
      cg_sb.check_result(got);
    end
  end

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(1, 0) ? 32'h0001_0000 : 32'hffff_0000;
      3: return $urandom;
      default: return $signed($urandom_range(393216)) - 196608; // within +-3.0
    endcase
  endfunction

  task automatic send_element(element_t e);
    @(negedge clk);
    start = 1;
    in_cur_pos = e.pos;
    in_gradient = e.grad;
    in_prev_gradient = e.pgrad;
    in_prev_direction = e.pdir;
    in_restart = e.restart;
    in_last_in = e.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    cg_sb.note_input(e);
    phase_items++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  // wait out every pending result plus the per-element processing time
  task automatic drain();
    @(negedge clk);
    start = 0;
    while (cg_sb.update_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [DW-1:0] data);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_STEP) cg_sb.step = data;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic send_vector(int len, bit restart, bit zero_prev);
    element_t e;
    for (int i = 0; i < len; i++) begin
      e.pos = pick_value();
      e.grad = pick_value();
      e.pgrad = zero_prev ? '0 : pick_value();
      e.pdir = pick_value();
      e.restart = (i == len - 1) ? restart : $urandom_range(1, 0);
      e.last = (i == len - 1);
      send_element(e);
    end
  endtask

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    element_t e;
    logic [DW-1:0] steps[4];
    int pcts[4];
    cg_sb = new();
    idle_pct = 0;
    phase_items = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;

    // directed: extremes, restart, zero denominator, ignored register index
    e = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, 1};
    send_element(e);
    e = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0};
    send_element(e);
    e = '{32'sh0001_0000, 32'sh8000_0000, 32'sh0000_0001, 32'sh7fff_ffff, 0, 1};
    send_element(e);
    send_vector(3, 1, 0);
    send_vector(3, 0, 1);
    send_vector(2, 1, 1);
    send_vector(4, 0, 0);
    drain();
    reg_write(3'd4, 32'h0000_0000);
    send_vector(2, 0, 0);
    drain();

    steps = '{32'hffff_ffff, 32'h0000_0000, 32'h0001_0000, $urandom};
    pcts = '{0, 63, 10, 0};
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(ADDR_STEP, steps[ph]);
      idle_pct = pcts[ph];
      phase_items = 0;
      while (phase_items < 70) begin
        case ($urandom_range(11))
          0: send_vector($urandom_range(68, 62), $urandom_range(1, 0), 0);
          1: send_vector($urandom_range(6, 1), 0, 1);
          2: begin
            send_vector($urandom_range(8, 1), $urandom_range(1, 0), 0);
            drain();
          end
          default: send_vector($urandom_range(8, 1), $urandom_range(3) == 0, 0);
        endcase
      end
      drain();
    end
    reg_write(ADDR_STEP, STEP_RESET);
    send_vector(5, 0, 0);
    drain();
    repeat (100) @(negedge clk);

    if (cg_sb.errors == 0 && cg_sb.update_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
